// ===== rtl/clpc_pkg.sv =====
// Package with the shared types, codes and constants of the CO2 line parser.
`default_nettype none
package clpc_pkg;

	// Controller states.
	typedef enum logic [3:0] {
		S_IDLE,
		S_CHK,
		S_PLO,
		S_PHI,
		S_PADD,
		S_YSAT,
		S_DLO,
		S_DHI,
		S_DADD,
		S_DPREP,
		S_DIV,
		S_FIN
	} state_t;

	// Datapath operation codes.
	typedef enum logic [3:0] {
		OP_NONE,
		OP_PLO,
		OP_PHI,
		OP_PADD,
		OP_YSAT,
		OP_DLO,
		OP_DHI,
		OP_DADD,
		OP_DPREP,
		OP_DIV,
		OP_LOAD
	} op_t;

	// Command from the controller to the datapath.
	typedef struct packed {
		logic       fire;
		op_t        op;
		logic [2:0] step;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic line_end;
		logic raw_big;
	} sts_t;

	localparam logic [7:0] CHR_LF    = 8'h0A;
	localparam logic [7:0] CHR_CR    = 8'h0D;
	localparam logic [7:0] CHR_ZERO  = 8'd48;
	localparam int         FOLD_POS  = 5;
	localparam int         T_W       = 56;
	localparam int         D_W       = 61;
	localparam int         Q_W       = 49;
	localparam int         DIV_STEPS = 84;
	localparam logic [2:0] TOP_STEP  = 3'd5;

	localparam logic signed [T_W-1:0] Y_MAX = 56'sd17592186044415;
	localparam logic signed [T_W-1:0] Y_MIN = -56'sd17592186044416;
	localparam logic signed [31:0]    X_POS = 32'sd4194304;
	localparam logic signed [31:0]    X_NEG = -32'sd4194304;
	localparam logic [47:0]           C_MAX = 48'h7FFF_FFFF_FFFF;
	localparam logic [47:0]           C_MIN = 48'h8000_0000_0000;

	// Polynomial coefficients, scaled to integers.
	function automatic logic signed [T_W-1:0] coef(input logic [2:0] k);
		logic signed [T_W-1:0] c;
		unique case (k)
			3'd0:    c = -56'sd1617381604;
			3'd1:    c = -56'sd19770802;
			3'd2:    c = 56'sd873071115;
			3'd3:    c = -56'sd12876160972;
			3'd4:    c = 56'sd86665665325;
			3'd5:    c = -56'sd273658019500;
			default: c = 56'sd328662488210;
		endcase
		return c;
	endfunction

endpackage
`default_nettype wire

// ===== rtl/clpc_if.sv =====
// Handshake interfaces for the received bytes and the result items.
`default_nettype none
interface clpc_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;
	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

interface clpc_out_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] raw_value;
	logic signed [44:0] poly_factor;
	logic signed [47:0] corrected_value;
	logic               divide_error;
	modport source (output valid, output raw_value, output poly_factor,
		output corrected_value, output divide_error, input ready);
	modport sink (input valid, input raw_value, input poly_factor,
		input corrected_value, input divide_error, output ready);
endinterface
`default_nettype wire

// ===== rtl/clpc_dp.sv =====
// Datapath: line parser, shared multiplier steps, divider and result register.
`default_nettype none
module clpc_dp #(
	parameter int MAX_LINE = 256
) (
	input  wire                       clk,
	input  wire                       arst_n,
	input  wire clpc_pkg::cmd_t       cmd,
	output clpc_pkg::sts_t            sts,
	input  wire [7:0]                 rx_byte,
	input  wire                       cfg_wr_en,
	input  wire signed [14:0]         cfg_wr_data,
	output logic signed [31:0]        raw_value,
	output logic signed [44:0]        poly_factor,
	output logic signed [47:0]        corrected_value,
	output logic                      divide_error
);
	localparam int PW = $clog2(MAX_LINE + 1);
	localparam logic [PW-1:0] P_MAX = PW'(MAX_LINE);

	logic [PW-1:0]                          pos_q;
	logic [7:0]                             last_q, prev_q;
	logic [31:0]                            acc_q, acc_next;
	logic                                   fold, line_end;
	logic signed [14:0]                     pres_q;
	logic signed [31:0]                     raw_q;
	logic                                   raw_big_q;
	logic signed [clpc_pkg::T_W-1:0]        t_q;
	logic signed [51:0]                     plo_q;
	logic signed [50:0]                     phi_q;
	logic signed [79:0]                     full;
	logic signed [79:0]                     shifted;
	logic signed [22:0]                     x23;
	logic signed [44:0]                     y_q;
	logic signed [38:0]                     dlo_q;
	logic signed [36:0]                     dhi_q;
	logic signed [clpc_pkg::D_W-1:0]        dprod;
	logic signed [clpc_pkg::D_W-1:0]        d_q;
	logic [clpc_pkg::D_W-1:0]               dm_q;
	logic [clpc_pkg::D_W-1:0]               rem_q, rem_n;
	logic [clpc_pkg::D_W:0]                 rem_sh;
	logic                                   ge;
	logic [clpc_pkg::Q_W-1:0]               q_q, q_n;
	logic                                   big_q, big_n;
	logic                                   dz_q, neg_q;
	logic [31:0]                            num_q;
	logic [47:0]                            corr;

	// Byte parser: decimal fold and line end detection.
	always_comb begin
		fold = (pos_q >= PW'(clpc_pkg::FOLD_POS));
		acc_next = fold ? ((acc_q << 3) + (acc_q << 1) + {24'd0, prev_q}
			- {24'd0, clpc_pkg::CHR_ZERO}) : acc_q;
		line_end = (rx_byte == clpc_pkg::CHR_LF) && (last_q == clpc_pkg::CHR_CR)
			&& (pos_q != '0);
		sts.line_end = line_end;
		sts.raw_big = raw_big_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			last_q <= '0;
			prev_q <= '0;
			acc_q <= '0;
			pres_q <= '0;
		end else begin
			if (cfg_wr_en) begin
				pres_q <= cfg_wr_data;
			end
			if (cmd.fire) begin
				prev_q <= last_q;
				last_q <= rx_byte;
				if (line_end) begin
					pos_q <= '0;
					acc_q <= '0;
				end else begin
					pos_q <= (pos_q < P_MAX) ? pos_q + 1'b1 : P_MAX;
					acc_q <= acc_next;
				end
			end
		end
	end

	// Horner step arithmetic.
	always_comb begin
		x23 = signed'(raw_q[22:0]);
		full = (80'(phi_q) <<< 28) + 80'(plo_q);
		shifted = (cmd.step == 3'd0) ? (full >>> 13) : (full >>> 22);
		dprod = (clpc_pkg::D_W'(dhi_q) <<< 23) + clpc_pkg::D_W'(dlo_q);
	end

	// One restoring divide step.
	always_comb begin
		rem_sh = {rem_q, num_q[31]};
		ge = (rem_sh >= {1'b0, dm_q});
		rem_n = ge ? clpc_pkg::D_W'(rem_sh - {1'b0, dm_q}) : rem_sh[clpc_pkg::D_W-1:0];
		q_n = big_q ? q_q : {q_q[clpc_pkg::Q_W-2:0], 1'b0};
		if (ge && !big_q) begin
			q_n[0] = 1'b1;
		end
		big_n = big_q || q_n[clpc_pkg::Q_W-1];
	end

	// Final saturation of the quotient.
	always_comb begin
		if (dz_q) begin
			if (raw_q[31]) begin
				corr = clpc_pkg::C_MIN;
			end else if (raw_q != 0) begin
				corr = clpc_pkg::C_MAX;
			end else begin
				corr = '0;
			end
		end else if (neg_q) begin
			corr = (big_q || q_q > {2'b01, 47'd0}) ? clpc_pkg::C_MIN : 48'(-q_q[47:0]);
		end else begin
			corr = (big_q || q_q > {1'b0, clpc_pkg::C_MAX}) ? clpc_pkg::C_MAX : q_q[47:0];
		end
	end

	// Sequenced datapath registers.
	always_ff @(posedge clk) begin
		if (cmd.fire && line_end) begin
			raw_q <= signed'(acc_next);
			raw_big_q <= (signed'(acc_next) >= clpc_pkg::X_POS)
				|| (signed'(acc_next) <= clpc_pkg::X_NEG);
			t_q <= clpc_pkg::coef(3'd6);
		end
		case (cmd.op)
			clpc_pkg::OP_PLO: plo_q <= 52'(x23) * 52'(signed'({1'b0, t_q[27:0]}));
			clpc_pkg::OP_PHI: phi_q <= 51'(x23) * 51'(signed'(t_q[55:28]));
			clpc_pkg::OP_PADD: t_q <= clpc_pkg::coef(cmd.step) + signed'(shifted[55:0]);
			clpc_pkg::OP_YSAT: begin
				if (raw_big_q || t_q > clpc_pkg::Y_MAX) begin
					y_q <= clpc_pkg::Y_MAX[44:0];
				end else if (t_q < clpc_pkg::Y_MIN) begin
					y_q <= clpc_pkg::Y_MIN[44:0];
				end else begin
					y_q <= t_q[44:0];
				end
			end
			clpc_pkg::OP_DLO: dlo_q <= 39'(signed'({1'b0, y_q[22:0]})) * 39'(pres_q);
			clpc_pkg::OP_DHI: dhi_q <= 37'(signed'(y_q[44:23])) * 37'(pres_q);
			clpc_pkg::OP_DADD: d_q <= (clpc_pkg::D_W'(1) <<< 44) - dprod;
			clpc_pkg::OP_DPREP: begin
				dm_q <= d_q[clpc_pkg::D_W-1] ? clpc_pkg::D_W'(-d_q) : d_q;
				dz_q <= (d_q == '0);
				neg_q <= raw_q[31] ^ d_q[clpc_pkg::D_W-1];
				num_q <= raw_q[31] ? 32'(-raw_q) : raw_q;
				rem_q <= '0;
				q_q <= '0;
				big_q <= 1'b0;
			end
			clpc_pkg::OP_DIV: begin
				rem_q <= rem_n;
				q_q <= q_n;
				big_q <= big_n;
				num_q <= {num_q[30:0], 1'b0};
			end
			clpc_pkg::OP_LOAD: begin
				raw_value <= raw_q;
				poly_factor <= y_q;
				corrected_value <= signed'(corr);
				divide_error <= dz_q;
			end
			default: begin
			end
		endcase
	end
endmodule
`default_nettype wire

// ===== rtl/clpc_ctrl.sv =====
// Controller: sequences the polynomial, the denominator and the divide.
`default_nettype none
module clpc_ctrl (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  in_valid,
	output logic                 in_ready,
	output logic                 out_valid,
	input  wire                  out_ready,
	input  wire clpc_pkg::sts_t  sts,
	output clpc_pkg::cmd_t       cmd
);
	clpc_pkg::state_t state_q, state_d;
	logic [2:0]       step_q, step_d;
	logic [6:0]       cnt_q, cnt_d;
	logic             out_valid_q, out_valid_d;
	logic             fire;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= clpc_pkg::S_IDLE;
			step_q <= '0;
			cnt_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			step_q <= step_d;
			cnt_q <= cnt_d;
			out_valid_q <= out_valid_d;
		end
	end

	// Next state and commands.
	always_comb begin
		state_d = state_q;
		step_d = step_q;
		cnt_d = cnt_q;
		out_valid_d = out_valid_q && !out_ready;
		in_ready = (state_q == clpc_pkg::S_IDLE);
		fire = in_valid && in_ready;
		cmd.fire = fire;
		cmd.op = clpc_pkg::OP_NONE;
		cmd.step = step_q;
		unique case (state_q)
			clpc_pkg::S_IDLE: begin
				if (fire && sts.line_end) begin
					state_d = clpc_pkg::S_CHK;
				end
			end
			clpc_pkg::S_CHK: begin
				step_d = clpc_pkg::TOP_STEP;
				state_d = sts.raw_big ? clpc_pkg::S_YSAT : clpc_pkg::S_PLO;
			end
			clpc_pkg::S_PLO: begin
				cmd.op = clpc_pkg::OP_PLO;
				state_d = clpc_pkg::S_PHI;
			end
			clpc_pkg::S_PHI: begin
				cmd.op = clpc_pkg::OP_PHI;
				state_d = clpc_pkg::S_PADD;
			end
			clpc_pkg::S_PADD: begin
				cmd.op = clpc_pkg::OP_PADD;
				if (step_q == 3'd0) begin
					state_d = clpc_pkg::S_YSAT;
				end else begin
					step_d = step_q - 1'b1;
					state_d = clpc_pkg::S_PLO;
				end
			end
			clpc_pkg::S_YSAT: begin
				cmd.op = clpc_pkg::OP_YSAT;
				state_d = clpc_pkg::S_DLO;
			end
			clpc_pkg::S_DLO: begin
				cmd.op = clpc_pkg::OP_DLO;
				state_d = clpc_pkg::S_DHI;
			end
			clpc_pkg::S_DHI: begin
				cmd.op = clpc_pkg::OP_DHI;
				state_d = clpc_pkg::S_DADD;
			end
			clpc_pkg::S_DADD: begin
				cmd.op = clpc_pkg::OP_DADD;
				state_d = clpc_pkg::S_DPREP;
			end
			clpc_pkg::S_DPREP: begin
				cmd.op = clpc_pkg::OP_DPREP;
				cnt_d = 7'(clpc_pkg::DIV_STEPS - 1);
				state_d = clpc_pkg::S_DIV;
			end
			clpc_pkg::S_DIV: begin
				cmd.op = clpc_pkg::OP_DIV;
				cnt_d = cnt_q - 1'b1;
				if (cnt_q == '0) begin
					state_d = clpc_pkg::S_FIN;
				end
			end
			clpc_pkg::S_FIN: begin
				// Load the result once the output register is free.
				if (!out_valid_q || out_ready) begin
					cmd.op = clpc_pkg::OP_LOAD;
					out_valid_d = 1'b1;
					state_d = clpc_pkg::S_IDLE;
				end
			end
			default: state_d = clpc_pkg::S_IDLE;
		endcase
		out_valid = out_valid_q;
	end

	// A line end leaves idle for the check state.
	a_line_end: assert property (@(posedge clk) disable iff (!arst_n)
		fire && sts.line_end |=> state_q == clpc_pkg::S_CHK)
		else $error("line end did not start the computation");

	// The divide loop ends in the finish state.
	a_div_done: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == clpc_pkg::S_DIV && cnt_q == '0 |=> state_q == clpc_pkg::S_FIN)
		else $error("divide loop overran");

	// A new result appears only from the finish state.
	a_out_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == clpc_pkg::S_FIN))
		else $error("result raised outside finish state");
endmodule
`default_nettype wire

// ===== rtl/co2_line_parse_pressure_correct_unit.sv =====
// A byte that does not end a line is taken at one per cycle while the block is idle.
// A line end byte starts the computation (check, six Horner steps, each a low product,
// a high product and an add on the shared multiplier, saturate, denominator, 84 divide steps,
// load once the output register is free); Horner is skipped when the raw value is out of range.
// No byte is taken during that computation; loading the result register frees the input.
// Reset clears the parser state, the pressure register and all control state.
`default_nettype none
module co2_line_parse_pressure_correct_unit #(
	parameter int MAX_LINE = 256
) (
	input  wire                clk,
	input  wire                arst_n,
	clpc_in_if.sink            rx_ch,
	clpc_out_if.source         res_ch,
	input  wire                cfg_wr_en,
	input  wire signed [14:0]  cfg_wr_data
);
	clpc_pkg::cmd_t cmd;
	clpc_pkg::sts_t sts;

	// Sequencer.
	clpc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (rx_ch.valid),
		.in_ready  (rx_ch.ready),
		.out_valid (res_ch.valid),
		.out_ready (res_ch.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// Arithmetic.
	clpc_dp #(.MAX_LINE(MAX_LINE)) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.sts             (sts),
		.rx_byte         (rx_ch.rx_byte),
		.cfg_wr_en       (cfg_wr_en),
		.cfg_wr_data     (cfg_wr_data),
		.raw_value       (res_ch.raw_value),
		.poly_factor     (res_ch.poly_factor),
		.corrected_value (res_ch.corrected_value),
		.divide_error    (res_ch.divide_error)
	);
endmodule
`default_nettype wire

// ===== dv/clpc_line_checker.sv =====
// Checker that predicts the result of every sensor line and compares it with the block.
`timescale 1ns / 100ps
`default_nettype none
module clpc_line_checker #(
	parameter int MAX_LINE = 256
) (
	input  wire                clk,
	input  wire                arst_n,
	clpc_in_if                 rx_mon,
	clpc_out_if                res_mon,
	input  wire                cfg_wr_en,
	input  wire signed [14:0]  cfg_wr_data,
	output int                 errors,
	output int                 pending,
	output int                 lines_checked,
	output int                 div_errors_seen
);
	// One expected line result at the widths of the result channel.
	typedef struct {
		logic signed [31:0] raw;
		logic signed [44:0] poly;
		logic signed [47:0] corr;
		logic               div_err;
	} line_result_t;

	localparam longint POLY_TOP = 64'sd17592186044415;
	localparam longint POLY_BOT = -64'sd17592186044416;
	localparam longint CORR_TOP = 64'sd140737488355327;
	localparam longint CORR_BOT = -64'sd140737488355328;
	localparam longint RAW_LIM  = 64'sd4194304;

	line_result_t      expected_lines[$];
	logic [12:0]       line_pos;
	logic [7:0]        prev_byte;
	logic [7:0]        prev_prev_byte;
	logic [31:0]       digit_sum;
	logic signed [14:0] pressure;

	// Horner scale factors of the sixth-order polynomial, lowest order first.
	longint coef_tab[7] = '{-64'sd1617381604, -64'sd19770802, 64'sd873071115,
		-64'sd12876160972, 64'sd86665665325, -64'sd273658019500, 64'sd328662488210};

	// Polynomial factor of the raw value, Q4.40, saturated.
	function automatic longint poly_of_raw(input int x);
		longint t;
		if (longint'(x) >= RAW_LIM || longint'(x) <= -RAW_LIM)
			return POLY_TOP;
		t = coef_tab[6];
		for (int k = 5; k >= 1; k--)
			t = coef_tab[k] + ((longint'(x) * t) >>> 22);
		t = coef_tab[0] + ((longint'(x) * t) >>> 13);
		if (t > POLY_TOP)
			t = POLY_TOP;
		if (t < POLY_BOT)
			t = POLY_BOT;
		return t;
	endfunction

	// Pressure-corrected value raw * 2^52 / (2^44 - y*P), truncated and saturated.
	function automatic longint corrected_of(input int raw, input longint y,
			input int p, output logic div_err);
		longint denom;
		logic [63:0] mag, dmag, rem, quo;
		logic overflow, negative, nb;
		denom = (64'sd1 <<< 44) - y * longint'(p);
		div_err = 1'b0;
		if (denom == 0) begin
			div_err = 1'b1;
			if (raw > 0)
				return CORR_TOP;
			if (raw < 0)
				return CORR_BOT;
			return 0;
		end
		mag = (raw < 0) ? 64'(-longint'(raw)) : 64'(longint'(raw));
		dmag = (denom < 0) ? 64'(-denom) : 64'(denom);
		rem = 0;
		quo = 0;
		overflow = 1'b0;
		for (int i = 83; i >= 0; i--) begin
			nb = (i >= 52) ? mag[i-52] : 1'b0;
			rem = {rem[62:0], nb};
			if (!overflow)
				quo = quo << 1;
			if (rem >= dmag) begin
				rem = rem - dmag;
				if (!overflow)
					quo[0] = 1'b1;
			end
			if (quo >= 64'h1_0000_0000_0000)
				overflow = 1'b1;
		end
		negative = (raw < 0) != (denom < 0);
		if (negative) begin
			if (overflow || quo > 64'(CORR_TOP) + 64'd1)
				return CORR_BOT;
			return -longint'(quo);
		end
		if (overflow || quo > 64'(CORR_TOP))
			return CORR_TOP;
		return longint'(quo);
	endfunction

	task automatic report_mismatch(input string what, input longint got, input longint want);
		$display("%0t: MISMATCH %s got %0d expected %0d", $realtime, what, got, want);
		errors++;
	endtask

	// Parser state follows every accepted item; line ends queue an expectation.
	always @(posedge clk or negedge arst_n) begin
		line_result_t exp_r;
		logic [12:0] pos_now;
		logic line_done;
		longint y;
		if (!arst_n) begin
			line_pos = 0;
			prev_byte = 0;
			prev_prev_byte = 0;
			digit_sum = 0;
			pressure = 0;
			expected_lines.delete();
			errors = 0;
			lines_checked = 0;
			div_errors_seen = 0;
		end else begin
			if (cfg_wr_en)
				pressure = cfg_wr_data;
			if (rx_mon.valid && rx_mon.ready) begin
				pos_now = line_pos;
				if (pos_now >= 5)
					digit_sum = digit_sum * 32'd10 + {24'd0, prev_prev_byte} - 32'd48;
				line_done = (rx_mon.rx_byte == clpc_pkg::CHR_LF) &&
					(prev_byte == clpc_pkg::CHR_CR) && (pos_now >= 1);
				prev_prev_byte = prev_byte;
				prev_byte = rx_mon.rx_byte;
				line_pos = (pos_now < MAX_LINE) ? pos_now + 13'd1 : 13'(MAX_LINE);
				if (line_done) begin
					y = poly_of_raw(int'(digit_sum));
					exp_r.raw = digit_sum;
					exp_r.poly = y[44:0];
					exp_r.corr = 48'(corrected_of(int'(digit_sum), y, int'(pressure),
						exp_r.div_err));
					expected_lines.push_back(exp_r);
					line_pos = 0;
					digit_sum = 0;
				end
			end
			if (res_mon.valid && res_mon.ready) begin
				if (expected_lines.size() == 0) begin
					report_mismatch("unexpected result, raw", res_mon.raw_value, 0);
				end else begin
					exp_r = expected_lines.pop_front();
					lines_checked++;
					if (res_mon.divide_error)
						div_errors_seen++;
					if (res_mon.raw_value !== exp_r.raw)
						report_mismatch("raw_value", res_mon.raw_value, exp_r.raw);
					if (res_mon.poly_factor !== exp_r.poly)
						report_mismatch("poly_factor", res_mon.poly_factor, exp_r.poly);
					if (res_mon.corrected_value !== exp_r.corr)
						report_mismatch("corrected_value", res_mon.corrected_value,
							exp_r.corr);
					if (res_mon.divide_error !== exp_r.div_err)
						report_mismatch("divide_error", res_mon.divide_error,
							exp_r.div_err);
				end
			end
		end
		pending = expected_lines.size();
	end

	// Anything still expected at the end is reported by the top through pending.
endmodule
`default_nettype wire

// ===== dv/tb_co2_line_parse_pressure_correct_unit.sv =====
// Top of the testbench: clock, reset, byte and register stimulus, and the verdict.
`timescale 1ns / 100ps
`default_nettype none
module tb_co2_line_parse_pressure_correct_unit;
	localparam int PHASE_BYTES = 300;

	logic              clk;
	logic              arst_n;
	logic              cfg_wr_en;
	logic signed [14:0] cfg_wr_data;
	logic              no_idle;
	logic              hold_req;
	int                errors;
	int                pending;
	int                lines_checked;
	int                div_errors_seen;
	int                bytes_sent;
	int                lines_sent;

	clpc_in_if  rx_ch();
	clpc_out_if res_ch();

	co2_line_parse_pressure_correct_unit uut (
		.clk(clk), .arst_n(arst_n), .rx_ch(rx_ch), .res_ch(res_ch),
		.cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
	);

	clpc_line_checker chk (
		.clk(clk), .arst_n(arst_n), .rx_mon(rx_ch), .res_mon(res_ch),
		.cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data), .errors(errors),
		.pending(pending), .lines_checked(lines_checked),
		.div_errors_seen(div_errors_seen)
	);

	initial clk = 1'b0;
	always #10 clk = ~clk;

	// Hard stop in case the block hangs.
	initial begin
		#50ms;
		$display("Timeout with %0d results outstanding", pending);
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// Result side: random stalls, plus one long hold-off on request.
	initial begin
		res_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				res_ch.ready = 1'b0;
				repeat (400) @(negedge clk);
				hold_req = 1'b0;
			end
			res_ch.ready = no_idle ? 1'b1 : ($urandom_range(0, 99) >= 10);
		end
	end

	// Offer one item and return at the falling edge after it is taken.
	task automatic send_byte(input logic [7:0] b);
		if (!no_idle) begin
			while ($urandom_range(0, 99) < 10) begin
				rx_ch.valid = 1'b0;
				@(negedge clk);
			end
		end
		rx_ch.valid = 1'b1;
		rx_ch.rx_byte = b;
		@(posedge clk);
		while (!rx_ch.ready)
			@(posedge clk);
		@(negedge clk);
		bytes_sent++;
	endtask

	// A well-formed line: three header bytes, the digit field, then CR LF.
	task automatic send_line(input int ndig, input logic wild_digits);
		repeat (3) send_byte(8'($urandom_range(32, 126)));
		repeat (ndig) send_byte(wild_digits ? 8'($urandom_range(0, 255)) :
			clpc_pkg::CHR_ZERO + 8'($urandom_range(0, 9)));
		send_byte(clpc_pkg::CHR_CR);
		send_byte(clpc_pkg::CHR_LF);
		lines_sent++;
	endtask

	task automatic drain_results();
		rx_ch.valid = 1'b0;
		@(negedge clk);
		wait (pending == 0);
		@(negedge clk);
	endtask

	// The register changes only with the block idle, past its line-end latency.
	task automatic set_pressure(input logic signed [14:0] p);
		drain_results();
		repeat (130) @(negedge clk);
		cfg_wr_en = 1'b1;
		cfg_wr_data = p;
		@(negedge clk);
		cfg_wr_en = 1'b0;
	endtask

	// Mostly well-formed lines with random content, the rest broken or noise.
	task automatic random_phase(input int nbytes, input logic pause_midway);
		int stop_at;
		int r;
		logic paused;
		stop_at = bytes_sent + nbytes;
		paused = 1'b0;
		while (bytes_sent < stop_at) begin
			r = $urandom_range(0, 99);
			if (pause_midway && !paused && bytes_sent > stop_at - nbytes / 2) begin
				drain_results();
				paused = 1'b1;
			end
			if (r < 65)
				send_line($urandom_range(0, 7), 1'b0);
			else if (r < 78)
				send_line($urandom_range(8, 12), 1'b0);
			else if (r < 90)
				send_line($urandom_range(0, 9), 1'b1);
			else if (r < 94)
				send_byte(clpc_pkg::CHR_CR);
			else if (r < 97)
				send_byte(clpc_pkg::CHR_LF);
			else
				repeat ($urandom_range(1, 5)) send_byte(8'($urandom_range(0, 255)));
		end
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_wr_data = '0;
		rx_ch.valid = 1'b0;
		rx_ch.rx_byte = '0;
		no_idle = 1'b0;
		hold_req = 1'b0;
		bytes_sent = 0;
		lines_sent = 0;
		repeat (3) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed: bare CR LF, short lines, byte extremes, the biggest raw values.
		send_byte(clpc_pkg::CHR_CR);
		send_byte(clpc_pkg::CHR_LF);
		send_line(0, 1'b0);
		send_byte(8'hFF);
		send_byte(8'h00);
		send_byte(clpc_pkg::CHR_CR);
		send_byte(clpc_pkg::CHR_LF);
		send_byte(clpc_pkg::CHR_LF);
		send_byte(clpc_pkg::CHR_CR);
		send_byte(clpc_pkg::CHR_CR);
		send_byte(clpc_pkg::CHR_LF);
		send_line(7, 1'b0);
		repeat (3) send_byte(8'h41);
		repeat (10) send_byte(8'h39);
		send_byte(clpc_pkg::CHR_CR);
		send_byte(clpc_pkg::CHR_LF);
		lines_sent += 4;

		// A line longer than the position counter saturates.
		send_line(300, 1'b1);
		random_phase(PHASE_BYTES, 1'b0);

		// Largest pressure, with a long result hold-off.
		set_pressure(15'sd16383);
		hold_req = 1'b1;
		random_phase(PHASE_BYTES, 1'b0);

		// Smallest pressure, with a pause until every result has come.
		set_pressure(-15'sd16384);
		random_phase(PHASE_BYTES, 1'b1);

		// Random pressure with no idling on either side.
		set_pressure(15'($urandom_range(0, 32767)));
		no_idle = 1'b1;
		random_phase(PHASE_BYTES, 1'b0);
		no_idle = 1'b0;

		set_pressure(15'sd1);
		random_phase(PHASE_BYTES, 1'b0);

		drain_results();
		repeat (150) @(negedge clk);
		$display("Sent %0d bytes in %0d line ends over five pressure settings,",
			bytes_sent, lines_sent);
		$display("checked %0d results, %0d of them with a zero divisor.",
			lines_checked, div_errors_seen);
		if (errors == 0 && pending == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end
endmodule
`default_nettype wire
